### sv/sdt_pkg.sv
// Shared types, constants and codes for the sighting dedupe table.
`default_nettype none

package sdt_pkg;

	// Table depth and derived index width
	localparam int MAX_ENTRIES = 24;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// Field widths fixed by the interface
	localparam int CNT_W  = 5;
	localparam int RIDX_W = 5;
	localparam int ADDR_W = 48;
	localparam int SIG_W  = 8;
	localparam int NAME_W = 16;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SIGHT = 2'd0;
	localparam kind_t KIND_CLEAR = 2'd1;
	localparam kind_t KIND_READ  = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_UPDATED  = 3'd0;
	localparam status_t ST_INSERTED = 3'd1;
	localparam status_t ST_DROPPED  = 3'd2;
	localparam status_t ST_CLEARED  = 3'd3;
	localparam status_t ST_READ_OK  = 3'd4;
	localparam status_t ST_BAD      = 3'd5;

	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic signed [SIG_W-1:0]  sig;
		logic [NAME_W-1:0]        name;
		logic                     classic;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Outcome of comparing one stored entry against the incoming sighting
	typedef struct packed {
		logic   hit;
		entry_t merged;
	} merge_t;

endpackage

`default_nettype wire

### sv/sdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/sdt_merge.sv
// Address compare and merge unit shared by every step of the table scan.
`default_nettype none

module sdt_merge (
	input  wire sdt_pkg::entry_t stored,
	input  wire sdt_pkg::entry_t incoming,
	output sdt_pkg::merge_t      result
);

	always_comb begin
		result.hit            = (stored.addr == incoming.addr);
		result.merged.addr    = stored.addr;
		// keep the stronger level, signed compare
		result.merged.sig     = (incoming.sig > stored.sig) ? incoming.sig : stored.sig;
		// take a name only if none is stored yet
		result.merged.name    = (stored.name == '0) ? incoming.name : stored.name;
		result.merged.classic = stored.classic;
	end

endmodule

`default_nettype wire

### sv/sighting_dedupe_table_core.sv
// Top level of the sighting dedupe table: sequencer, entry RAM and result registers.
//
// Usage: present an item on kind and its payload ports with start high; the beat
// is taken at a rising edge where start is high and busy is low. busy stays high
// while a sighting scan or an indexed read is under way.
// Every item yields exactly one result beat: done pulses for one cycle with
// status, entry_index, entry_count and the entry fields. The receiver cannot
// stall, so the result registers simply hold until the next beat overwrites them.
// Paths from accept to done:
//   clear, unused kind, out-of-range read, sighting into an empty table: answered from idle
//   read in range: through S_READ, after one RAM read
//   sighting: a scan in S_SCAN; one stored entry is compared per cycle
//   by the single compare/merge unit, paced by the one RAM read port.
// The next item may start in the cycle done is shown.
// Reset (arst_n low) empties the table and returns to idle; the entry RAM is not
// cleared, since only entries below the fill count are ever read.
`default_nettype none

module sighting_dedupe_table_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire sdt_pkg::kind_t               kind,
	input  wire logic [sdt_pkg::ADDR_W-1:0]   device_address,
	input  wire logic signed [sdt_pkg::SIG_W-1:0] signal_level,
	input  wire logic [sdt_pkg::NAME_W-1:0]   name_ref,
	input  wire logic                         is_classic,
	input  wire logic [sdt_pkg::RIDX_W-1:0]   read_index,
	output logic                              done,
	output sdt_pkg::status_t                  status,
	output logic [sdt_pkg::RIDX_W-1:0]        entry_index,
	output logic [sdt_pkg::CNT_W-1:0]         entry_count,
	output logic [sdt_pkg::ADDR_W-1:0]        out_address,
	output logic signed [sdt_pkg::SIG_W-1:0]  out_signal,
	output logic [sdt_pkg::NAME_W-1:0]        out_name_ref,
	output logic                              out_classic
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Fill count and scan pointer
	logic [sdt_pkg::CNT_W-1:0] filled_q, filled_d;
	logic [sdt_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [sdt_pkg::CNT_W-1:0] idx_inc;
	logic                      scan_last;

	// Latched item
	sdt_pkg::entry_t            item_q;
	logic [sdt_pkg::RIDX_W-1:0] ridx_q;
	sdt_pkg::entry_t            port_entry;

	// Result registers
	logic                       done_q, done_d;
	sdt_pkg::status_t           status_q, status_d;
	logic [sdt_pkg::RIDX_W-1:0] eidx_q, eidx_d;
	logic [sdt_pkg::CNT_W-1:0]  ecount_q, ecount_d;
	sdt_pkg::entry_t            res_q, res_d;

	// RAM port
	logic                      ram_we;
	logic [sdt_pkg::IDX_W-1:0] ram_waddr;
	logic [sdt_pkg::IDX_W-1:0] ram_raddr;
	sdt_pkg::entry_t           ram_wdata;
	logic [sdt_pkg::ENTRY_W-1:0] ram_rdata_raw;
	sdt_pkg::entry_t           ram_rdata;

	sdt_pkg::merge_t           merge;

	assign port_entry.addr    = device_address;
	assign port_entry.sig     = signal_level;
	assign port_entry.name    = name_ref;
	assign port_entry.classic = is_classic;

	assign ram_rdata = sdt_pkg::entry_t'(ram_rdata_raw);

	sdt_ram #(
		.WIDTH(sdt_pkg::ENTRY_W),
		.DEPTH(sdt_pkg::MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	// One compare/merge per cycle against the entry read last cycle
	sdt_merge u_merge (
		.stored  (ram_rdata),
		.incoming(item_q),
		.result  (merge)
	);

	assign idx_inc   = sdt_pkg::CNT_W'(idx_q) + sdt_pkg::CNT_W'(1);
	assign scan_last = (idx_inc >= filled_q);

	always_comb begin
		state_d   = state_q;
		filled_d  = filled_q;
		idx_d     = idx_q;
		done_d    = 1'b0;
		status_d  = status_q;
		eidx_d    = eidx_q;
		ecount_d  = ecount_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = item_q;
		ram_raddr = idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (kind)
						sdt_pkg::KIND_SIGHT: begin
							if (filled_q == '0) begin
								// empty table: append straight from the ports
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = port_entry;
								filled_d  = sdt_pkg::CNT_W'(1);
								done_d    = 1'b1;
								status_d  = sdt_pkg::ST_INSERTED;
								eidx_d    = '0;
								ecount_d  = sdt_pkg::CNT_W'(1);
								res_d     = port_entry;
							end else begin
								ram_raddr = '0;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						sdt_pkg::KIND_CLEAR: begin
							filled_d = '0;
							done_d   = 1'b1;
							status_d = sdt_pkg::ST_CLEARED;
							eidx_d   = '0;
							ecount_d = '0;
							res_d    = '0;
						end
						sdt_pkg::KIND_READ: begin
							if (sdt_pkg::CNT_W'(read_index) < filled_q) begin
								ram_raddr = read_index[sdt_pkg::IDX_W-1:0];
								state_d   = S_READ;
							end else begin
								done_d   = 1'b1;
								status_d = sdt_pkg::ST_BAD;
								eidx_d   = read_index;
								ecount_d = filled_q;
								res_d    = '0;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = sdt_pkg::ST_BAD;
							eidx_d   = '0;
							ecount_d = filled_q;
							res_d    = '0;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (merge.hit) begin
					// update in place and stop
					ram_we    = 1'b1;
					ram_waddr = idx_q;
					ram_wdata = merge.merged;
					done_d    = 1'b1;
					status_d  = sdt_pkg::ST_UPDATED;
					eidx_d    = sdt_pkg::RIDX_W'(idx_q);
					ecount_d  = filled_q;
					res_d     = merge.merged;
					state_d   = S_IDLE;
				end else if (!scan_last) begin
					// advance to the next entry
					ram_raddr = sdt_pkg::IDX_W'(idx_inc);
					idx_d     = sdt_pkg::IDX_W'(idx_inc);
				end else if (filled_q >= sdt_pkg::MAX_COUNT) begin
					// no match and no room: drop
					done_d   = 1'b1;
					status_d = sdt_pkg::ST_DROPPED;
					eidx_d   = '0;
					ecount_d = filled_q;
					res_d    = '0;
					state_d  = S_IDLE;
				end else begin
					// no match: append at the fill count
					ram_we    = 1'b1;
					ram_waddr = filled_q[sdt_pkg::IDX_W-1:0];
					ram_wdata = item_q;
					filled_d  = filled_q + sdt_pkg::CNT_W'(1);
					done_d    = 1'b1;
					status_d  = sdt_pkg::ST_INSERTED;
					eidx_d    = sdt_pkg::RIDX_W'(filled_q);
					ecount_d  = filled_q + sdt_pkg::CNT_W'(1);
					res_d     = item_q;
					state_d   = S_IDLE;
				end
			end
			S_READ: begin
				done_d   = 1'b1;
				status_d = sdt_pkg::ST_READ_OK;
				eidx_d   = ridx_q;
				ecount_d = filled_q;
				res_d    = ram_rdata;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			filled_q <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			filled_q <= filled_d;
			idx_q    <= idx_d;
			done_q   <= done_d;
		end
	end

	// Payload: latch the item on accept, hold results until the next beat
	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			item_q <= port_entry;
			ridx_q <= read_index;
		end
		status_q <= status_d;
		eidx_q   <= eidx_d;
		ecount_q <= ecount_d;
		res_q    <= res_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign entry_index  = eidx_q;
	assign entry_count  = ecount_q;
	assign out_address  = res_q.addr;
	assign out_signal   = res_q.sig;
	assign out_name_ref = res_q.name;
	assign out_classic  = res_q.classic;

`ifndef SYNTHESIS
	// Fill count never exceeds the table depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= sdt_pkg::MAX_COUNT)
		else $error("fill count above table depth");

	// Fill count moves only together with a result beat
	a_fill_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(filled_q) |-> done_q)
		else $error("fill count changed without a result");

	// An insert lands at the last filled entry
	a_insert_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == sdt_pkg::ST_INSERTED) |->
			(ecount_q == sdt_pkg::CNT_W'(eidx_q) + sdt_pkg::CNT_W'(1)))
		else $error("insert not at table tail");

	// An update or a good read names a filled entry
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == sdt_pkg::ST_UPDATED || status_q == sdt_pkg::ST_READ_OK)) |->
			(sdt_pkg::CNT_W'(eidx_q) < ecount_q))
		else $error("entry index outside filled range");

	// Going busy needs an accepted start
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without a start");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for sighting_dedupe_table_core, with an in-bench table predictor.
`default_nettype none

module tb;
	import sdt_pkg::*;

	// Kind code with no function; the block must reject it without touching the table
	localparam kind_t KIND_UNUSED = 2'd3;
	localparam int    TARGET_BEATS = 650;
	localparam int    IDLE_PCT     = 29;

	// One input beat, field by field at the port widths
	typedef struct packed {
		kind_t                    kind;
		logic [ADDR_W-1:0]        addr;
		logic signed [SIG_W-1:0]  sig;
		logic [NAME_W-1:0]        name;
		logic                     classic;
		logic [RIDX_W-1:0]        ridx;
	} sight_beat_t;

	// One result beat as the table should report it
	typedef struct packed {
		status_t            status;
		logic [RIDX_W-1:0]  idx;
		logic [CNT_W-1:0]   count;
		entry_t             ent;
	} table_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	kind_t                     kind;
	logic [ADDR_W-1:0]         device_address;
	logic signed [SIG_W-1:0]   signal_level;
	logic [NAME_W-1:0]         name_ref;
	logic                      is_classic;
	logic [RIDX_W-1:0]         read_index;
	logic                      done;
	status_t                   status;
	logic [RIDX_W-1:0]         entry_index;
	logic [CNT_W-1:0]          entry_count;
	logic [ADDR_W-1:0]         out_address;
	logic signed [SIG_W-1:0]   out_signal;
	logic [NAME_W-1:0]         out_name_ref;
	logic                      out_classic;

	// Predictor copy of the table: only entries below table_fill are meaningful
	entry_t        table_copy [MAX_ENTRIES];
	int            table_fill;
	// Results still owed by the block, oldest first
	table_result_t owed_results [$];
	int            errors;
	int            beats_sent;
	int            status_seen [8];
	bit            gaps_on;

	sighting_dedupe_table_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.device_address (device_address),
		.signal_level   (signal_level),
		.name_ref       (name_ref),
		.is_classic     (is_classic),
		.read_index     (read_index),
		.done           (done),
		.status         (status),
		.entry_index    (entry_index),
		.entry_count    (entry_count),
		.out_address    (out_address),
		.out_signal     (out_signal),
		.out_name_ref   (out_name_ref),
		.out_classic    (out_classic)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one item to the table copy and return the result the block owes for it
	function automatic table_result_t predict_table(input sight_beat_t b);
		table_result_t r;
		bit            hit;
		r   = '0;
		hit = 1'b0;
		case (b.kind)
			KIND_SIGHT: begin
				// Search filled entries in order; the first address match wins
				for (int i = 0; i < table_fill; i++) begin
					if (!hit && table_copy[i].addr == b.addr) begin
						hit = 1'b1;
						// Keep the stronger level; an unknown level of 0 beats any negative one
						if ($signed(b.sig) > $signed(table_copy[i].sig))
							table_copy[i].sig = b.sig;
						// Take the name only if the entry has none; the classic flag never moves
						if (b.name != '0 && table_copy[i].name == '0)
							table_copy[i].name = b.name;
						r.status = ST_UPDATED;
						r.idx    = RIDX_W'(i);
						r.ent    = table_copy[i];
					end
				end
				if (!hit) begin
					if (table_fill >= MAX_ENTRIES) begin
						// Table full: drop, all entry fields read as zero
						r.status = ST_DROPPED;
					end else begin
						table_copy[table_fill] = '{addr: b.addr, sig: b.sig, name: b.name,
							classic: b.classic};
						r.status   = ST_INSERTED;
						r.idx      = RIDX_W'(table_fill);
						r.ent      = table_copy[table_fill];
						table_fill = table_fill + 1;
					end
				end
			end
			KIND_CLEAR: begin
				table_fill = 0;
				r.status   = ST_CLEARED;
			end
			KIND_READ: begin
				// Out-of-range reads echo the index but show no entry
				r.idx = b.ridx;
				if (b.ridx < table_fill) begin
					r.status = ST_READ_OK;
					r.ent    = table_copy[b.ridx];
				end else begin
					r.status = ST_BAD;
				end
			end
			default: begin
				r.status = ST_BAD;
			end
		endcase
		r.count = CNT_W'(table_fill);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic sight_beat_t random_beat();
		sight_beat_t b;
		b.kind    = kind_t'($urandom_range(3));
		b.addr    = rand_addr();
		b.sig     = SIG_W'($urandom);
		b.name    = NAME_W'($urandom);
		b.classic = 1'($urandom_range(1));
		b.ridx    = RIDX_W'($urandom);
		return b;
	endfunction

	function automatic sight_beat_t make_beat(input kind_t k, input logic [ADDR_W-1:0] a,
			input logic signed [SIG_W-1:0] s, input logic [NAME_W-1:0] n, input logic c,
			input logic [RIDX_W-1:0] ri);
		return '{kind: k, addr: a, sig: s, name: n, classic: c, ridx: ri};
	endfunction

	task automatic drive_beat(input sight_beat_t b);
		kind           = b.kind;
		device_address = b.addr;
		signal_level   = b.sig;
		name_ref       = b.name;
		is_classic     = b.classic;
		read_index     = b.ridx;
	endtask

	// Present one beat at the falling edge, hold it until the block takes it,
	// then log the result it owes. start is left high so the next beat can follow
	// back to back; whoever stops sending drops it.
	task automatic send_beat(input sight_beat_t b);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			// Mostly short gaps, now and then a longer one that can outlast a full table scan
			gap   = ($urandom_range(7) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
			start = 1'b0;
			repeat (gap) begin
				drive_beat(random_beat());
				@(negedge clk);
			end
		end
		drive_beat(b);
		start = 1'b1;
		do @(posedge clk); while (busy);
		owed_results.push_back(predict_table(b));
		beats_sent++;
	endtask

	// Drop start and hold off until every owed result has come back
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endfunction

	// Check every result beat against the oldest owed result; it can't be held off,
	// so take it on the edge that ends the done cycle
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				$error("result beat with none owed: status %0d index %0d", status, entry_index);
				errors++;
			end else begin
				want = owed_results.pop_front();
				status_seen[want.status]++;
				check_field("status", ADDR_W'(want.status), ADDR_W'(status));
				check_field("entry_index", ADDR_W'(want.idx), ADDR_W'(entry_index));
				check_field("entry_count", ADDR_W'(want.count), ADDR_W'(entry_count));
				check_field("out_address", want.ent.addr, out_address);
				check_field("out_signal", ADDR_W'(want.ent.sig), ADDR_W'(out_signal));
				check_field("out_name_ref", ADDR_W'(want.ent.name), ADDR_W'(out_name_ref));
				check_field("out_classic", ADDR_W'(want.ent.classic), ADDR_W'(out_classic));
			end
		end
	end

	// Random sequence: clear, then sightings drawn from a small address pool
	// (some pool entries one bit away from their neighbor) mixed with reads,
	// a few mid-run clears and a few unused kinds. Walking the pool in order
	// half the time makes big pools fill the table and hit the full-table drop.
	task automatic run_sequence(input int n_items, input int pool_size);
		logic [ADDR_W-1:0] pool [$];
		int                cursor;
		int                roll;
		sight_beat_t       b;
		pool = {};
		for (int k = 0; k < pool_size; k++) begin
			if (k > 0 && $urandom_range(4) == 0)
				pool.push_back(pool[k-1] ^ (48'd1 << $urandom_range(ADDR_W-1)));
			else
				pool.push_back(rand_addr());
		end
		b      = random_beat();
		b.kind = KIND_CLEAR;
		send_beat(b);
		cursor = 0;
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(99);
			b    = random_beat();
			if (roll < 70) begin
				b.kind = KIND_SIGHT;
				if ($urandom_range(1)) begin
					b.addr = pool[cursor % pool_size];
					cursor++;
				end else begin
					b.addr = pool[$urandom_range(pool_size-1)];
				end
				if ($urandom_range(2) == 0)
					b.name = '0;
				if ($urandom_range(9) == 0)
					b.sig = '0;
			end else if (roll < 92) begin
				b.kind = KIND_READ;
				if (table_fill > 0 && $urandom_range(3) != 0)
					b.ridx = RIDX_W'($urandom_range(table_fill-1));
			end else if (roll < 97) begin
				b.kind = KIND_CLEAR;
			end else begin
				b.kind = KIND_UNUSED;
			end
			send_beat(b);
		end
	endtask

	// Empty table: reads at both index extremes, the unused kind, clear,
	// then a sighting into the empty table
	task automatic test_empty_table();
		send_beat(make_beat(KIND_READ, rand_addr(), 8'sd5, 16'h00A5, 1'b1, 5'd0));
		send_beat(make_beat(KIND_READ, rand_addr(), -8'sd3, 16'h5A00, 1'b0, 5'd31));
		send_beat(make_beat(KIND_UNUSED, rand_addr(), 8'sd1, 16'h0001, 1'b1, 5'd7));
		send_beat(make_beat(KIND_CLEAR, rand_addr(), 8'sd0, 16'h0000, 1'b0, 5'd0));
		send_beat(make_beat(KIND_SIGHT, 48'h0123_4567_89AB, -8'sd60, 16'h0000, 1'b0, 5'd0));
	endtask

	// Merge rules on one address: stronger level wins, 0 beats negatives, the
	// name is taken only when empty, the classic flag stays as first stored
	task automatic test_merge_rules();
		logic [ADDR_W-1:0] a;
		a = 48'hA5A5_0F0F_C3C3;
		send_beat(make_beat(KIND_CLEAR, '0, 8'sd0, 16'h0000, 1'b0, 5'd0));
		send_beat(make_beat(KIND_SIGHT, a, -8'sd90, 16'h0000, 1'b1, 5'd0));
		send_beat(make_beat(KIND_SIGHT, a, 8'sd0, 16'h1234, 1'b0, 5'd0));
		send_beat(make_beat(KIND_SIGHT, a, -8'sd128, 16'hFFFF, 1'b0, 5'd0));
		send_beat(make_beat(KIND_SIGHT, a, 8'sd127, 16'h0000, 1'b1, 5'd0));
		send_beat(make_beat(KIND_READ, '0, 8'sd0, 16'h0000, 1'b0, 5'd0));
	endtask

	// Address and field extremes, near-miss addresses, reads in and out of range
	task automatic test_field_extremes();
		send_beat(make_beat(KIND_SIGHT, '0, -8'sd1, 16'hFFFF, 1'b0, 5'd31));
		send_beat(make_beat(KIND_SIGHT, '1, 8'sd127, 16'h0001, 1'b1, 5'd0));
		send_beat(make_beat(KIND_SIGHT, 48'h8000_0000_0000, -8'sd128, 16'h8000, 1'b1, 5'd0));
		send_beat(make_beat(KIND_SIGHT, '1, -8'sd128, 16'h7FFF, 1'b0, 5'd0));
		send_beat(make_beat(KIND_READ, '1, 8'sd0, 16'h0000, 1'b1, 5'd3));
		send_beat(make_beat(KIND_READ, '0, 8'sd0, 16'h0000, 1'b0, 5'd4));
		send_beat(make_beat(KIND_READ, '0, 8'sd0, 16'h0000, 1'b0, 5'd31));
	endtask

	// Long stretch with the sender never idling
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		run_sequence(70, 28);
		gaps_on = 1'b1;
	endtask

	// Bulk of the run: random sequences, sometimes waiting for the block to drain
	task automatic test_random_sequences();
		while (beats_sent < TARGET_BEATS) begin
			run_sequence($urandom_range(70, 10), $urandom_range(40, 1));
			if ($urandom_range(3) == 0)
				drain_results();
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		errors     = 0;
		beats_sent = 0;
		table_fill = 0;
		gaps_on    = 1'b1;
		foreach (status_seen[i])
			status_seen[i] = 0;
		drive_beat('0);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_merge_rules();
		test_field_extremes();
		// Pause the sender until the block has answered everything
		drain_results();
		test_back_to_back();
		test_random_sequences();

		drain_results();
		// Let a late, unowed result show up if there is one
		repeat (MAX_ENTRIES + 4) @(posedge clk);

		$display("%0d beats checked: %0d inserted, %0d updated, %0d dropped on a full table",
			beats_sent, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
			status_seen[ST_DROPPED]);
		$display("%0d clears, %0d reads in range, %0d rejected reads or kinds",
			status_seen[ST_CLEARED], status_seen[ST_READ_OK], status_seen[ST_BAD]);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog: many times the slowest correct run
	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
